// ===== design/tzrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tzrsp_pkg
// Types, character codes and constants of the timezone rule string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tzrsp_pkg;

  typedef enum logic [2:0] {
    PH_STD,
    PH_DST,
    PH_IGN,
    PH_ERR,
    PH_RULE,
    PH_OFS
  } phase_t;

  localparam logic [2:0] KIND_STD   = 3'd0;
  localparam logic [2:0] KIND_DST   = 3'd1;
  localparam logic [2:0] KIND_ZONE  = 3'd2;
  localparam logic [2:0] KIND_START = 3'd3;
  localparam logic [2:0] KIND_END   = 3'd4;

  localparam logic [1:0] RT_JULIAN0 = 2'd0;
  localparam logic [1:0] RT_JULIAN1 = 2'd1;
  localparam logic [1:0] RT_MWD     = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UJ    = 8'h4A;
  localparam logic [7:0] CH_UM    = 8'h4D;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'd32;

  localparam logic [15:0] NUM_SAT   = 16'd65535;
  localparam logic [16:0] DAY_SEC   = 17'd86400;
  localparam logic [11:0] HOUR_SEC  = 12'd3600;
  localparam logic [5:0]  MIN_SEC   = 6'd60;
  localparam logic [12:0] RULE_TIME = 13'd7200;
  localparam logic [11:0] DST_SHIFT = 12'd3600;
  localparam logic [15:0] JDAY_MAX  = 16'd365;
  localparam logic [15:0] MONTH_MAX = 16'd12;
  localparam logic [15:0] WEEK_MAX  = 16'd5;
  localparam logic [15:0] WDAY_MAX  = 16'd6;

  typedef struct packed {
    logic [1:0]         rtype;
    logic signed [29:0] roff;
    logic [3:0]         month;
    logic [2:0]         week;
    logic [2:0]         day;
  } rule_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         name_char;
    logic               status;
    logic               daylight;
    logic signed [28:0] std_ofs;
    logic signed [28:0] dst_ofs;
    logic [1:0]         rtype;
    logic signed [29:0] roff;
    logic [3:0]         month;
    logic [2:0]         week;
    logic [2:0]         day;
    logic               last;
  } rec_t;

  function automatic logic [15:0] take_digit(logic [15:0] num, logic [7:0] ch);
    logic [19:0] v;
    v = 20'(num) * 20'd10 + 20'(ch[3:0]);
    return (v > 20'(NUM_SAT)) ? NUM_SAT : v[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/tz_rule_string_parser.sv =====
// ----------------------------------------------------------------------------
// tz_rule_string_parser
// Parses a POSIX-style timezone string one character per beat and emits
// name letters, a zone record and, for daylight zones, two rule records.
// ----------------------------------------------------------------------------
// Latency: a record enters the output queue at the accepting edge and shows
//   on out_valid in the next cycle.
// Throughput: one character per cycle while the output queue holds at most
//   one entry; a terminator of a daylight zone queues three records and input
//   stalls until the 4-entry queue is back to one entry.
// Reset: synchronous, active low; parser returns to the start of the std name
//   and the output queue empties.
`default_nettype none

module tz_rule_string_parser #(
  parameter int NAME_MAX_LEN = 7
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_char_code,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_record_kind,
  output logic [7:0]              out_name_char,
  output logic                    out_status,
  output logic                    out_daylight,
  output logic signed [28:0]      out_std_offset,
  output logic signed [28:0]      out_dst_offset,
  output logic [1:0]              out_rule_type,
  output logic signed [29:0]      out_rule_offset,
  output logic [3:0]              out_rule_month,
  output logic [2:0]              out_rule_week,
  output logic [2:0]              out_rule_day,
  output logic                    out_last
);

  localparam int CNT_W = $clog2(NAME_MAX_LEN + 1);
  localparam int QDEPTH = 4;
  localparam int QP_W = $clog2(QDEPTH);
  localparam int QC_W = $clog2(QDEPTH + 1);

  tzrsp_pkg::phase_t phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [15:0]       num_r, num_nxt;
  logic              seen_r, seen_nxt;
  logic              minus_r, minus_nxt;
  logic [15:0]       hour_r, hour_nxt;
  logic [15:0]       min_r, min_nxt;
  logic signed [28:0] std_r, std_nxt;
  logic signed [28:0] dst_r, dst_nxt;
  logic              hd_r, hd_nxt;
  logic [1:0]        ctx_r, ctx_nxt;
  logic [1:0]        sub_r, sub_nxt;
  logic              ridx_r, ridx_nxt;
  logic              rnum_r, rnum_nxt;
  tzrsp_pkg::rule_t  rule_r [2];
  tzrsp_pkg::rule_t  rule_nxt [2];

  logic        acc;
  logic [7:0]  ch;
  logic        is_alpha, is_digit;
  logic [15:0] dig_num;
  logic [8:0]  day9;
  logic [29:0] day_sec;
  logic [15:0] h_sel, m_sel, s_sel;
  logic [28:0] tot_mag;
  logic signed [28:0] tot;

  logic        name_go;
  logic [2:0]  name_kind;
  logic        ofs0_go, ofs_begin;
  logic [1:0]  ofs_ctx;
  logic        fin_go, done_go, follow_go, follow_r, start_go, start_idx;
  logic        fail_go, end_go, end_valid;
  logic        fin_hd;
  logic signed [28:0] fin_std, fin_dst;
  tzrsp_pkg::rule_t fin_r0, fin_r1;

  tzrsp_pkg::rec_t push_rec [3];
  logic [1:0]      push_n;
  tzrsp_pkg::rec_t q_r [QDEPTH];
  logic [QP_W-1:0] wr_r, rd_r;
  logic [QC_W-1:0] qcnt_r;
  logic            pop;

  assign in_ready = qcnt_r <= QC_W'(QDEPTH - 3);
  assign acc      = in_valid && in_ready;
  assign ch       = in_char_code;
  assign is_alpha = (ch >= tzrsp_pkg::CH_UA && ch <= tzrsp_pkg::CH_UZ) ||
                    (ch >= tzrsp_pkg::CH_LA && ch <= tzrsp_pkg::CH_LZ);
  assign is_digit = ch >= tzrsp_pkg::CH_ZERO && ch <= tzrsp_pkg::CH_NINE;
  assign dig_num  = tzrsp_pkg::take_digit(num_r, ch);

  assign day9    = (rule_r[ridx_r].rtype == tzrsp_pkg::RT_JULIAN1) ? num_r[8:0]
                                                                   : num_r[8:0] - 9'd1;
  assign day_sec = 30'(day9) * 30'(tzrsp_pkg::DAY_SEC);

  assign h_sel   = (sub_r == 2'd1) ? num_r : hour_r;
  assign m_sel   = (sub_r == 2'd2) ? num_r : min_r;
  assign s_sel   = (sub_r == 2'd3) ? num_r : 16'd0;
  assign tot_mag = 29'(h_sel) * 29'(tzrsp_pkg::HOUR_SEC) +
                   29'(m_sel) * 29'(tzrsp_pkg::MIN_SEC) + 29'(s_sel);
  assign tot     = minus_r ? -$signed(tot_mag) : $signed(tot_mag);

  always_comb begin
    phase_nxt = phase_r;  cnt_nxt = cnt_r;    num_nxt = num_r;   seen_nxt = seen_r;
    minus_nxt = minus_r;  hour_nxt = hour_r;  min_nxt = min_r;   std_nxt = std_r;
    dst_nxt = dst_r;      hd_nxt = hd_r;      ctx_nxt = ctx_r;   sub_nxt = sub_r;
    ridx_nxt = ridx_r;    rnum_nxt = rnum_r;
    rule_nxt[0] = rule_r[0];
    rule_nxt[1] = rule_r[1];
    name_go = 1'b0;  name_kind = tzrsp_pkg::KIND_STD;
    ofs0_go = 1'b0;  ofs_begin = 1'b0;  ofs_ctx = 2'd0;
    fin_go = 1'b0;   done_go = 1'b0;    follow_go = 1'b0;  follow_r = 1'b0;
    start_go = 1'b0; start_idx = 1'b0;  fail_go = 1'b0;
    end_go = 1'b0;   end_valid = 1'b0;
    fin_hd = 1'b0;   fin_std = '0;      fin_dst = '0;
    fin_r0 = '0;     fin_r1 = '0;

    if (acc) begin
      unique case (phase_r)
        tzrsp_pkg::PH_STD: begin
          if (is_alpha && cnt_r < CNT_W'(NAME_MAX_LEN)) begin
            cnt_nxt = cnt_r + CNT_W'(1);
            name_go = 1'b1;
            name_kind = tzrsp_pkg::KIND_STD;
          end else if (cnt_r == '0) begin
            fail_go = 1'b1;
          end else begin
            ofs0_go = 1'b1;
            ofs_begin = 1'b1;
            ofs_ctx = 2'd0;
          end
        end
        tzrsp_pkg::PH_DST: begin
          if (is_alpha && cnt_r < CNT_W'(NAME_MAX_LEN)) begin
            cnt_nxt = cnt_r + CNT_W'(1);
            name_go = 1'b1;
            name_kind = tzrsp_pkg::KIND_DST;
          end else begin
            ofs0_go = 1'b1;
            ofs_begin = 1'b1;
            ofs_ctx = 2'd1;
          end
        end
        tzrsp_pkg::PH_IGN: begin
          if (ch == tzrsp_pkg::CH_NUL) begin
            end_go = 1'b1;
            end_valid = 1'b1;
          end
        end
        tzrsp_pkg::PH_RULE: begin
          if (!rnum_r) begin
            rnum_nxt = 1'b1;
            if (ch == tzrsp_pkg::CH_UJ) begin
              rule_nxt[ridx_r].rtype = tzrsp_pkg::RT_JULIAN1;
            end else if (ch == tzrsp_pkg::CH_UM) begin
              rule_nxt[ridx_r].rtype = tzrsp_pkg::RT_MWD;
            end else if (is_digit) begin
              rule_nxt[ridx_r].rtype = tzrsp_pkg::RT_JULIAN0;
              num_nxt = dig_num;
              seen_nxt = 1'b1;
            end else begin
              fail_go = 1'b1;
            end
          end else if (is_digit) begin
            num_nxt = dig_num;
            seen_nxt = 1'b1;
          end else if (!seen_r) begin
            fail_go = 1'b1;
          end else if (rule_r[ridx_r].rtype == tzrsp_pkg::RT_JULIAN1) begin
            if (num_r > tzrsp_pkg::JDAY_MAX) begin
              fail_go = 1'b1;
            end else begin
              rule_nxt[ridx_r].roff = $signed(day_sec);
              done_go = 1'b1;
            end
          end else if (rule_r[ridx_r].rtype == tzrsp_pkg::RT_JULIAN0) begin
            if (num_r < 16'd1 || num_r > tzrsp_pkg::JDAY_MAX) begin
              fail_go = 1'b1;
            end else begin
              rule_nxt[ridx_r].roff = $signed(day_sec);
              done_go = 1'b1;
            end
          end else if (rule_r[ridx_r].month == 4'd0) begin
            if (num_r < 16'd1 || num_r > tzrsp_pkg::MONTH_MAX ||
                ch != tzrsp_pkg::CH_DOT) begin
              fail_go = 1'b1;
            end else begin
              rule_nxt[ridx_r].month = num_r[3:0];
              num_nxt = '0;
              seen_nxt = 1'b0;
            end
          end else if (rule_r[ridx_r].week == 3'd0) begin
            if (num_r < 16'd1 || num_r > tzrsp_pkg::WEEK_MAX ||
                ch != tzrsp_pkg::CH_DOT) begin
              fail_go = 1'b1;
            end else begin
              rule_nxt[ridx_r].week = num_r[2:0];
              num_nxt = '0;
              seen_nxt = 1'b0;
            end
          end else begin
            if (num_r > tzrsp_pkg::WDAY_MAX) begin
              fail_go = 1'b1;
            end else begin
              rule_nxt[ridx_r].day = num_r[2:0];
              done_go = 1'b1;
            end
          end
        end
        tzrsp_pkg::PH_OFS: begin
          ofs_ctx = ctx_r;
          if (sub_r == 2'd0) begin
            ofs0_go = 1'b1;
          end else if (is_digit) begin
            num_nxt = dig_num;
            seen_nxt = 1'b1;
          end else if (!seen_r) begin
            fail_go = 1'b1;
          end else if (sub_r == 2'd1) begin
            hour_nxt = num_r;
            if (ch == tzrsp_pkg::CH_COLON) begin
              sub_nxt = 2'd2;
              num_nxt = '0;
              seen_nxt = 1'b0;
            end else begin
              fin_go = 1'b1;
            end
          end else if (sub_r == 2'd2) begin
            min_nxt = num_r;
            if (ch == tzrsp_pkg::CH_COLON) begin
              sub_nxt = 2'd3;
              num_nxt = '0;
              seen_nxt = 1'b0;
            end else begin
              fin_go = 1'b1;
            end
          end else begin
            fin_go = 1'b1;
          end
        end
        default: begin
          fail_go = 1'b1;
        end
      endcase
    end

    if (ofs0_go) begin
      if (ofs_begin) begin
        phase_nxt = tzrsp_pkg::PH_OFS;
        ctx_nxt = ofs_ctx;
        sub_nxt = 2'd0;
        num_nxt = '0;
        seen_nxt = 1'b0;
        minus_nxt = 1'b0;
        hour_nxt = '0;
        min_nxt = '0;
      end
      if (ch == tzrsp_pkg::CH_PLUS) begin
        sub_nxt = 2'd1;
      end else if (ch == tzrsp_pkg::CH_MINUS) begin
        minus_nxt = 1'b1;
        sub_nxt = 2'd1;
      end else if (is_digit) begin
        num_nxt = 16'(ch[3:0]);
        seen_nxt = 1'b1;
        sub_nxt = 2'd1;
      end else if (ofs_ctx == 2'd1) begin
        dst_nxt = std_r - 29'(tzrsp_pkg::DST_SHIFT);
        if (ch == tzrsp_pkg::CH_COMMA) begin
          start_go = 1'b1;
          start_idx = 1'b0;
        end else begin
          fail_go = 1'b1;
        end
      end else begin
        fail_go = 1'b1;
      end
    end

    if (fin_go) begin
      unique case (ofs_ctx)
        2'd0: begin
          std_nxt = tot;
          if (is_alpha) begin
            hd_nxt = 1'b1;
            phase_nxt = tzrsp_pkg::PH_DST;
            cnt_nxt = CNT_W'(1);
            name_go = 1'b1;
            name_kind = tzrsp_pkg::KIND_DST;
          end else if (ch == tzrsp_pkg::CH_NUL) begin
            end_go = 1'b1;
            end_valid = 1'b1;
          end else begin
            phase_nxt = tzrsp_pkg::PH_IGN;
          end
        end
        2'd1: begin
          dst_nxt = tot;
          if (ch == tzrsp_pkg::CH_COMMA) begin
            start_go = 1'b1;
            start_idx = 1'b0;
          end else begin
            fail_go = 1'b1;
          end
        end
        default: begin
          rule_nxt[ofs_ctx[0]].roff = rule_r[ofs_ctx[0]].roff + 30'(tot);
          follow_go = 1'b1;
          follow_r = ofs_ctx[0];
        end
      endcase
    end

    if (done_go) begin
      if (ch == tzrsp_pkg::CH_SLASH) begin
        phase_nxt = tzrsp_pkg::PH_OFS;
        ctx_nxt = {1'b1, ridx_r};
        sub_nxt = 2'd0;
        num_nxt = '0;
        seen_nxt = 1'b0;
        minus_nxt = 1'b0;
        hour_nxt = '0;
        min_nxt = '0;
      end else begin
        rule_nxt[ridx_r].roff = rule_nxt[ridx_r].roff + 30'(tzrsp_pkg::RULE_TIME);
        follow_go = 1'b1;
        follow_r = ridx_r;
      end
    end

    if (follow_go) begin
      if (!follow_r) begin
        if (ch == tzrsp_pkg::CH_COMMA) begin
          start_go = 1'b1;
          start_idx = 1'b1;
        end else begin
          fail_go = 1'b1;
        end
      end else if (ch == tzrsp_pkg::CH_NUL) begin
        end_go = 1'b1;
        end_valid = 1'b1;
      end else begin
        fail_go = 1'b1;
      end
    end

    if (start_go) begin
      phase_nxt = tzrsp_pkg::PH_RULE;
      ridx_nxt = start_idx;
      rnum_nxt = 1'b0;
      rule_nxt[start_idx] = '0;
      num_nxt = '0;
      seen_nxt = 1'b0;
    end

    if (fail_go) begin
      if (ch == tzrsp_pkg::CH_NUL) begin
        end_go = 1'b1;
        end_valid = 1'b0;
      end else begin
        phase_nxt = tzrsp_pkg::PH_ERR;
      end
    end

    if (end_go) begin
      fin_hd = hd_nxt;
      fin_std = std_nxt;
      fin_dst = dst_nxt;
      fin_r0 = rule_nxt[0];
      fin_r1 = rule_nxt[1];
      phase_nxt = tzrsp_pkg::PH_STD;
      cnt_nxt = '0;
      hd_nxt = 1'b0;
    end
  end

  always_comb begin
    push_rec[0] = '0;
    push_rec[1] = '0;
    push_rec[2] = '0;
    push_n = 2'd0;
    if (name_go) begin
      push_rec[0].kind = name_kind;
      push_rec[0].name_char = (ch >= tzrsp_pkg::CH_LA && ch <= tzrsp_pkg::CH_LZ) ?
                              ch - tzrsp_pkg::CASE_GAP : ch;
      push_n = 2'd1;
    end else if (end_go) begin
      push_rec[0].kind = tzrsp_pkg::KIND_ZONE;
      push_rec[0].status = !end_valid;
      push_rec[0].daylight = end_valid && fin_hd;
      push_rec[0].std_ofs = end_valid ? fin_std : '0;
      push_rec[0].dst_ofs = (end_valid && fin_hd) ? fin_dst : '0;
      push_rec[0].last = !(end_valid && fin_hd);
      push_rec[1].kind = tzrsp_pkg::KIND_START;
      push_rec[1].rtype = fin_r0.rtype;
      push_rec[1].roff = fin_r0.roff;
      push_rec[1].month = fin_r0.month;
      push_rec[1].week = fin_r0.week;
      push_rec[1].day = fin_r0.day;
      push_rec[2].kind = tzrsp_pkg::KIND_END;
      push_rec[2].rtype = fin_r1.rtype;
      push_rec[2].roff = fin_r1.roff;
      push_rec[2].month = fin_r1.month;
      push_rec[2].week = fin_r1.week;
      push_rec[2].day = fin_r1.day;
      push_rec[2].last = 1'b1;
      push_n = (end_valid && fin_hd) ? 2'd3 : 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tzrsp_pkg::PH_STD;
      cnt_r <= '0;
      hd_r <= 1'b0;
      minus_r <= 1'b0;
      seen_r <= 1'b0;
      num_r <= '0;
      hour_r <= '0;
      min_r <= '0;
      ctx_r <= '0;
      sub_r <= '0;
      ridx_r <= 1'b0;
      rnum_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
      hd_r <= hd_nxt;
      minus_r <= minus_nxt;
      seen_r <= seen_nxt;
      num_r <= num_nxt;
      hour_r <= hour_nxt;
      min_r <= min_nxt;
      ctx_r <= ctx_nxt;
      sub_r <= sub_nxt;
      ridx_r <= ridx_nxt;
      rnum_r <= rnum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    std_r <= std_nxt;
    dst_r <= dst_nxt;
    rule_r[0] <= rule_nxt[0];
    rule_r[1] <= rule_nxt[1];
  end

  assign out_valid = qcnt_r != '0;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      qcnt_r <= '0;
    end else begin
      wr_r <= wr_r + QP_W'(push_n);
      rd_r <= rd_r + QP_W'(pop);
      qcnt_r <= qcnt_r + QC_W'(push_n) - QC_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (QC_W'(i) < QC_W'(push_n)) begin
        q_r[wr_r + QP_W'(i)] <= push_rec[i];
      end
    end
  end

  assign out_record_kind = q_r[rd_r].kind;
  assign out_name_char   = q_r[rd_r].name_char;
  assign out_status      = q_r[rd_r].status;
  assign out_daylight    = q_r[rd_r].daylight;
  assign out_std_offset  = q_r[rd_r].std_ofs;
  assign out_dst_offset  = q_r[rd_r].dst_ofs;
  assign out_rule_type   = q_r[rd_r].rtype;
  assign out_rule_offset = q_r[rd_r].roff;
  assign out_rule_month  = q_r[rd_r].month;
  assign out_rule_week   = q_r[rd_r].week;
  assign out_rule_day    = q_r[rd_r].day;
  assign out_last        = q_r[rd_r].last;

  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QC_W'(QDEPTH))
    else $error("output queue overflow");

  a_name_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NAME_MAX_LEN))
    else $error("name count beyond limit");

  a_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_record_kind == tzrsp_pkg::KIND_START |=>
    out_valid && out_record_kind == tzrsp_pkg::KIND_END)
    else $error("end rule does not follow start rule");

  a_bad_zone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == tzrsp_pkg::KIND_ZONE && out_status |->
    !out_daylight && out_last)
    else $error("invalid zone carries daylight");

endmodule

`default_nettype wire
